@@ rtl/tpac_pkg.sv @@
`default_nettype none

package tpac_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ADC_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_2 = 3'd5;

    typedef struct packed {
        logic valid;
        logic zero;
        logic neg;
    } t_ctl;

endpackage

`default_nettype wire

@@ rtl/tpac_cfg.sv @@
`default_nettype none

module tpac_cfg #(
    parameter int ADC_BITS   = 10,
    parameter int VALUE_BITS = 16,
    parameter int CFG_W      = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tpac_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]               i_cfg_data,
    output logic [ADC_BITS-1:0]                 o_adc_0,
    output logic [ADC_BITS-1:0]                 o_adc_1,
    output logic [ADC_BITS-1:0]                 o_adc_2,
    output logic signed [VALUE_BITS-1:0]        o_value_0,
    output logic signed [VALUE_BITS-1:0]        o_value_1,
    output logic signed [VALUE_BITS-1:0]        o_value_2
);
    import tpac_pkg::*;

    logic [ADC_BITS-1:0]   r_adc_0, r_adc_1, r_adc_2;
    logic [VALUE_BITS-1:0] r_value_0, r_value_1, r_value_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_0   <= '0;
            r_adc_1   <= '0;
            r_adc_2   <= '0;
            r_value_0 <= '0;
            r_value_1 <= '0;
            r_value_2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ADC_0:   r_adc_0   <= i_cfg_data[ADC_BITS-1:0];
                CFG_ADC_1:   r_adc_1   <= i_cfg_data[ADC_BITS-1:0];
                CFG_ADC_2:   r_adc_2   <= i_cfg_data[ADC_BITS-1:0];
                CFG_VALUE_0: r_value_0 <= i_cfg_data[VALUE_BITS-1:0];
                CFG_VALUE_1: r_value_1 <= i_cfg_data[VALUE_BITS-1:0];
                CFG_VALUE_2: r_value_2 <= i_cfg_data[VALUE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_adc_0   = r_adc_0;
    assign o_adc_1   = r_adc_1;
    assign o_adc_2   = r_adc_2;
    assign o_value_0 = $signed(r_value_0);
    assign o_value_1 = $signed(r_value_1);
    assign o_value_2 = $signed(r_value_2);

endmodule

`default_nettype wire

@@ rtl/tpac_front.sv @@
`default_nettype none

module tpac_front #(
    parameter int ADC_BITS   = 10,
    parameter int VALUE_BITS = 16,
    parameter int NW         = ADC_BITS + VALUE_BITS + 3,
    parameter int RW         = NW + 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic [ADC_BITS-1:0]            i_adc_sample,
    input  wire logic [ADC_BITS-1:0]            i_adc_0,
    input  wire logic [ADC_BITS-1:0]            i_adc_1,
    input  wire logic [ADC_BITS-1:0]            i_adc_2,
    input  wire logic signed [VALUE_BITS-1:0]   i_value_0,
    input  wire logic signed [VALUE_BITS-1:0]   i_value_1,
    input  wire logic signed [VALUE_BITS-1:0]   i_value_2,
    output tpac_pkg::t_ctl                      o_ctl,
    output logic [RW-1:0]                       o_rem,
    output logic [ADC_BITS:0]                   o_den
);
    import tpac_pkg::*;

    localparam int A = ADC_BITS;
    localparam int V = VALUE_BITS;

    // stage 1: segment select and differences
    logic [A-1:0]        n_ai, n_aj;
    logic signed [V-1:0] n_vi, n_vj;
    logic signed [A:0]   n_dx, n_den1;
    logic signed [V:0]   n_dv;
    logic                n_below;
    t_ctl                n_ctl1;

    t_ctl                r_ctl1;
    logic signed [A:0]   r_dx1, r_den1;
    logic signed [V:0]   r_dv1;
    logic signed [V-1:0] r_vi1;

    always_comb begin
        n_below = (i_adc_sample < i_adc_0);
        if (i_adc_sample < i_adc_1) begin
            n_ai = i_adc_0;
            n_aj = i_adc_1;
            n_vi = i_value_0;
            n_vj = i_value_1;
        end else begin
            n_ai = i_adc_1;
            n_aj = i_adc_2;
            n_vi = i_value_1;
            n_vj = i_value_2;
        end
        n_dx   = $signed({1'b0, i_adc_sample}) - $signed({1'b0, n_ai});
        n_den1 = $signed({1'b0, n_aj}) - $signed({1'b0, n_ai});
        n_dv   = (V+1)'(n_vj) - (V+1)'(n_vi);
        n_ctl1.valid = i_valid;
        n_ctl1.zero  = n_below || (n_den1 == '0) || (n_dv == '0);
        n_ctl1.neg   = 1'b0;
    end

    // stage 2: products
    t_ctl                    r_ctl2;
    logic signed [A+V:0]     r_p1;
    logic signed [A+V+1:0]   r_p2;
    logic signed [A:0]       r_den2;

    // stage 3: numerator
    t_ctl                    r_ctl3;
    logic signed [NW-1:0]    r_num;
    logic signed [A:0]       r_den3;

    // stage 4: magnitudes and sign
    t_ctl                    r_ctl4;
    logic [NW-1:0]           r_an;
    logic [A-1:0]            r_ad;
    logic                    n_neg;

    // stage 5: rounded dividend and divisor
    t_ctl                    r_ctl5;
    logic [RW-1:0]           r_rem;
    logic [A:0]              r_dd;

    assign n_neg = r_num[NW-1] ^ r_den3[A];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            r_ctl5 <= '0;
        end else begin
            r_ctl1 <= n_ctl1;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= '{valid: r_ctl3.valid, zero: r_ctl3.zero, neg: n_neg};
            r_ctl5 <= r_ctl4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx1  <= n_dx;
        r_den1 <= n_den1;
        r_dv1  <= n_dv;
        r_vi1  <= n_vi;

        r_p1   <= (A+V+1)'(r_vi1) * (A+V+1)'(r_den1);
        r_p2   <= (A+V+2)'(r_dx1) * (A+V+2)'(r_dv1);
        r_den2 <= r_den1;

        r_num  <= NW'(r_p1) + NW'(r_p2);
        r_den3 <= r_den2;

        r_an   <= r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
        r_ad   <= r_den3[A] ? A'(-r_den3) : A'(r_den3);

        r_rem  <= {r_an, 1'b0} + RW'(r_ad);
        r_dd   <= {r_ad, 1'b0};
    end

    assign o_ctl = r_ctl5;
    assign o_rem = r_rem;
    assign o_den = r_dd;

endmodule

`default_nettype wire

@@ rtl/tpac_div_stage.sv @@
`default_nettype none

module tpac_div_stage #(
    parameter int RW    = 30,
    parameter int DW    = 11,
    parameter int QW    = 17,
    parameter int SHIFT = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  tpac_pkg::t_ctl       i_ctl,
    input  wire logic [RW-1:0]   i_rem,
    input  wire logic [DW-1:0]   i_den,
    input  wire logic [QW-1:0]   i_quo,
    output tpac_pkg::t_ctl       o_ctl,
    output logic [RW-1:0]        o_rem,
    output logic [DW-1:0]        o_den,
    output logic [QW-1:0]        o_quo
);
    import tpac_pkg::*;

    logic [RW-1:0] n_den_sh;
    logic [RW:0]   n_trial;
    logic          n_bit;

    t_ctl          r_ctl;
    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_quo;

    always_comb begin
        n_den_sh = RW'(i_den) << SHIFT;
        n_trial  = {1'b0, i_rem} - {1'b0, n_den_sh};
        n_bit    = !n_trial[RW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_bit ? n_trial[RW-1:0] : i_rem;
        r_den <= i_den;
        r_quo <= {i_quo[QW-2:0], n_bit};
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

`default_nettype wire

@@ rtl/three_point_adc_calibration_top.sv @@
`default_nettype none

// Three-point ADC calibration: maps each raw sample to a physical value by
// piecewise-linear interpolation through three points set over the config
// port, rounded half away from zero and saturated to VALUE_BITS signed; a
// sample below the first point, or on a segment with equal codes or equal
// values, yields zero. busy is always low: a sample is taken on every cycle
// that start is high, and each one yields exactly one result, strobed by
// o_valid for one cycle. The pipeline runs five stages of segment select,
// multiplication and rounding set-up, then the restoring divider, one
// quotient bit per stage over VALUE_BITS + 1 stages, then one output
// register. The receiver cannot stall; results must be taken on the strobe.
// Write calibration registers only while no samples are in flight.

module three_point_adc_calibration_top #(
    parameter int ADC_BITS   = 10,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [ADC_BITS-1:0]             i_adc_sample,
    input  wire logic                            i_cfg_we,
    input  wire logic [tpac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [((ADC_BITS > VALUE_BITS) ? ADC_BITS : VALUE_BITS)-1:0] i_cfg_data,
    output logic                                 o_valid,
    output logic signed [VALUE_BITS-1:0]         o_physical_value,
    output logic                                 o_saturated
);
    import tpac_pkg::*;

    localparam int A     = ADC_BITS;
    localparam int V     = VALUE_BITS;
    localparam int CFG_W = (A > V) ? A : V;
    localparam int NW    = A + V + 3;
    localparam int RW    = NW + 1;
    localparam int DW    = A + 1;
    localparam int QW    = V + 1;
    localparam int NDIV  = V + 1;

    logic [A-1:0]        w_adc_0, w_adc_1, w_adc_2;
    logic signed [V-1:0] w_value_0, w_value_1, w_value_2;

    t_ctl                w_ctl [0:NDIV];
    logic [RW-1:0]       w_rem [0:NDIV];
    logic [DW-1:0]       w_den [0:NDIV];
    logic [QW-1:0]       w_quo [0:NDIV];

    assign busy = 1'b0;

    tpac_cfg #(
        .ADC_BITS   (A),
        .VALUE_BITS (V),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_adc_0    (w_adc_0),
        .o_adc_1    (w_adc_1),
        .o_adc_2    (w_adc_2),
        .o_value_0  (w_value_0),
        .o_value_1  (w_value_1),
        .o_value_2  (w_value_2)
    );

    tpac_front #(
        .ADC_BITS   (A),
        .VALUE_BITS (V),
        .NW         (NW),
        .RW         (RW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start && !busy),
        .i_adc_sample (i_adc_sample),
        .i_adc_0      (w_adc_0),
        .i_adc_1      (w_adc_1),
        .i_adc_2      (w_adc_2),
        .i_value_0    (w_value_0),
        .i_value_1    (w_value_1),
        .i_value_2    (w_value_2),
        .o_ctl        (w_ctl[0]),
        .o_rem        (w_rem[0]),
        .o_den        (w_den[0])
    );

    assign w_quo[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NDIV; g++) begin : g_div
            tpac_div_stage #(
                .RW    (RW),
                .DW    (DW),
                .QW    (QW),
                .SHIFT (V - g)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_rem   (w_rem[g]),
                .i_den   (w_den[g]),
                .i_quo   (w_quo[g]),
                .o_ctl   (w_ctl[g+1]),
                .o_rem   (w_rem[g+1]),
                .o_den   (w_den[g+1]),
                .o_quo   (w_quo[g+1])
            );
        end
    endgenerate

    t_ctl          w_fin;
    logic          n_big;
    logic [V-1:0]  n_q;
    logic          n_sat;
    logic [V-1:0]  n_value;

    logic          r_valid;
    logic [V-1:0]  r_value;
    logic          r_sat;

    assign w_fin = w_ctl[NDIV];

    always_comb begin
        n_big = w_quo[NDIV][V];
        n_q   = w_quo[NDIV][V-1:0];
        if (w_fin.zero) begin
            n_sat   = 1'b0;
            n_value = '0;
        end else if (w_fin.neg) begin
            n_sat   = n_big || (n_q[V-1] && (n_q[V-2:0] != '0));
            n_value = n_sat ? {1'b1, {(V-1){1'b0}}} : V'(-n_q);
        end else begin
            n_sat   = n_big || n_q[V-1];
            n_value = n_sat ? {1'b0, {(V-1){1'b1}}} : n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_sat   <= n_sat;
    end

    assign o_valid          = r_valid;
    assign o_physical_value = $signed(r_value);
    assign o_saturated      = r_sat;

endmodule

`default_nettype wire

@@ sim/tb_three_point_adc_calibration_top.sv @@
`timescale 1ns / 100ps

module tb_three_point_adc_calibration_top;
    import tpac_pkg::*;

    localparam int ADC_BITS   = 10;
    localparam int VALUE_BITS = 16;
    localparam int DATA_BITS  = 16;
    localparam int LATENCY    = VALUE_BITS + 7;
    localparam int RANDOM_ITEMS = 700;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

    localparam longint VALUE_MAX = 32767;
    localparam longint VALUE_MIN = -32768;

    typedef struct {
        logic [ADC_BITS-1:0]          sample;
        logic signed [VALUE_BITS-1:0] value;
        logic                         sat;
    } t_cal_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [ADC_BITS-1:0]          i_adc_sample = '0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_idx = '0;
    logic [DATA_BITS-1:0]         i_cfg_data = '0;
    logic                         o_valid;
    logic signed [VALUE_BITS-1:0] o_physical_value;
    logic                         o_saturated;

    logic [ADC_BITS-1:0]          cal_adc_m [3];
    logic signed [VALUE_BITS-1:0] cal_val_m [3];

    t_cal_result pending_q [$];
    t_cal_result oldest;
    int          error_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;

    three_point_adc_calibration_top #(
        .ADC_BITS   (ADC_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_adc_sample     (i_adc_sample),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_physical_value (o_physical_value),
        .o_saturated      (o_saturated)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void calibrate_sample(input logic [ADC_BITS-1:0] sample,
                                             output logic signed [VALUE_BITS-1:0] value,
                                             output logic sat);
        longint x, ai, aj, vi, vj, den, dv, num, an, ad, q;
        int     lo_pt;
        bit     neg;
        value = '0;
        sat   = 1'b0;
        x = longint'(sample);
        if (x < longint'(cal_adc_m[0]))
            return;
        lo_pt = (x < longint'(cal_adc_m[1])) ? 0 : 1;
        ai  = longint'(cal_adc_m[lo_pt]);
        aj  = longint'(cal_adc_m[lo_pt + 1]);
        vi  = longint'(cal_val_m[lo_pt]);
        vj  = longint'(cal_val_m[lo_pt + 1]);
        den = aj - ai;
        dv  = vj - vi;
        if (den == 0 || dv == 0)
            return;
        num = vi * den + (x - ai) * dv;
        neg = (num < 0) != (den < 0);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        q   = (2 * an + ad) / (2 * ad);
        if (neg)
            q = -q;
        if (q > VALUE_MAX) begin
            sat = 1'b1;
            q = VALUE_MAX;
        end else if (q < VALUE_MIN) begin
            sat = 1'b1;
            q = VALUE_MIN;
        end
        value = q[VALUE_BITS-1:0];
    endfunction

    task automatic send_sample(input logic [ADC_BITS-1:0] sample);
        t_cal_result item;
        int          gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start        <= 1'b1;
        i_adc_sample <= sample;
        do @(posedge i_clk); while (busy);
        item.sample = sample;
        calibrate_sample(sample, item.value, item.sat);
        pending_q.push_back(item);
        items_sent++;
        burst_left--;
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ADC_0:   cal_adc_m[0] = data[ADC_BITS-1:0];
            CFG_ADC_1:   cal_adc_m[1] = data[ADC_BITS-1:0];
            CFG_ADC_2:   cal_adc_m[2] = data[ADC_BITS-1:0];
            CFG_VALUE_0: cal_val_m[0] = data[VALUE_BITS-1:0];
            CFG_VALUE_1: cal_val_m[1] = data[VALUE_BITS-1:0];
            CFG_VALUE_2: cal_val_m[2] = data[VALUE_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_calibration(input logic [ADC_BITS-1:0] a0, a1, a2,
                                    input logic signed [VALUE_BITS-1:0] v0, v1, v2);
        logic [31:0] junk;
        junk = $urandom;
        wait_drain();
        write_reg(CFG_ADC_0, {junk[5:0], a0});
        write_reg(CFG_ADC_1, {junk[11:6], a1});
        write_reg(CFG_ADC_2, {junk[17:12], a2});
        write_reg(CFG_VALUE_0, v0);
        write_reg(CFG_VALUE_1, v1);
        write_reg(CFG_VALUE_2, v2);
        if ($urandom_range(0, 3) == 0)
            write_reg(junk[31] ? CFG_UNUSED_7 : CFG_UNUSED_6, 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("result %0d/%0b with no pending transaction",
                                          o_physical_value, o_saturated));
            end else begin
                oldest = pending_q.pop_front();
                if (o_physical_value !== oldest.value)
                    report_mismatch($sformatf("sample %0d: physical_value %0d, want %0d",
                                              oldest.sample, o_physical_value, oldest.value));
                if (o_saturated !== oldest.sat)
                    report_mismatch($sformatf("sample %0d: saturated %b, want %b",
                                              oldest.sample, o_saturated, oldest.sat));
            end
        end
    end

    task automatic test_reset_state();
        send_sample(10'd0);
        send_sample(10'd512);
        send_sample(10'd1023);
    endtask

    task automatic test_interpolation();
        load_calibration(10'd100, 10'd500, 10'd900, -16'sd1000, 16'sd2000, 16'sd30000);
        send_sample(10'd0);
        send_sample(10'd99);
        send_sample(10'd100);
        send_sample(10'd333);
        send_sample(10'd500);
        send_sample(10'd777);
        send_sample(10'd1023);
    endtask

    task automatic test_saturation();
        load_calibration(10'd0, 10'd1, 10'd2, -16'sd32768, 16'sd0, 16'sd32767);
        send_sample(10'd0);
        send_sample(10'd1023);
        load_calibration(10'd0, 10'd1023, 10'd1022, 16'sd0, 16'sd32767, -16'sd32768);
        send_sample(10'd1023);
    endtask

    task automatic test_rounding();
        load_calibration(10'd0, 10'd2, 10'd4, 16'sd0, 16'sd1, 16'sd0);
        send_sample(10'd1);
        send_sample(10'd3);
        load_calibration(10'd0, 10'd2, 10'd4, 16'sd0, -16'sd1, 16'sd0);
        send_sample(10'd1);
        send_sample(10'd3);
    endtask

    task automatic test_degenerate_segments();
        load_calibration(10'd10, 10'd20, 10'd20, 16'sd5, 16'sd6, 16'sd7);
        send_sample(10'd15);
        send_sample(10'd30);
        load_calibration(10'd10, 10'd20, 10'd30, 16'sd100, 16'sd100, -16'sd5);
        send_sample(10'd15);
        send_sample(10'd25);
    endtask

    task automatic test_points_out_of_order();
        load_calibration(10'd50, 10'd40, 10'd10, 16'sd300, -16'sd700, 16'sd1234);
        send_sample(10'd49);
        send_sample(10'd60);
        load_calibration(10'd10, 10'd900, 10'd300, -16'sd50, 16'sd800, 16'sd20000);
        send_sample(10'd950);
    endtask

    task automatic test_unused_index();
        wait_drain();
        write_reg(CFG_UNUSED_6, 16'hffff);
        write_reg(CFG_UNUSED_7, 16'h5a5a);
        i_cfg_we <= 1'b0;
        send_sample(10'd600);
        send_sample(10'd950);
    endtask

    function automatic logic [ADC_BITS-1:0] pick_adc();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return '1;
            default: return ADC_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic randomize_calibration();
        logic [ADC_BITS-1:0]          a [3];
        logic [ADC_BITS-1:0]          swap;
        logic signed [VALUE_BITS-1:0] v [3];
        int                           mode;
        mode = $urandom_range(0, 3);
        foreach (a[i]) begin
            a[i] = ADC_BITS'($urandom);
            v[i] = VALUE_BITS'($urandom);
        end
        case (mode)
            0: begin
                for (int p = 0; p < 2; p++)
                    for (int k = 0; k < 2 - p; k++)
                        if (a[k] > a[k + 1]) begin
                            swap = a[k];
                            a[k] = a[k + 1];
                            a[k + 1] = swap;
                        end
            end
            2: begin
                foreach (a[i]) begin
                    a[i] = pick_adc();
                    v[i] = pick_value();
                end
            end
            3: begin
                a[0] = ADC_BITS'($urandom_range(0, 990));
                a[1] = a[0] + ADC_BITS'($urandom_range(1, 8));
                a[2] = a[1] + ADC_BITS'($urandom_range(0, 8));
                foreach (v[i])
                    v[i] = VALUE_BITS'(int'($urandom_range(0, 40)) - 20);
            end
            default: ;
        endcase
        load_calibration(a[0], a[1], a[2], v[0], v[1], v[2]);
    endtask

    task automatic test_random_phases();
        int n;
        int s;
        while (items_sent < RANDOM_ITEMS) begin
            randomize_calibration();
            n = $urandom_range(10, 50);
            repeat (n) begin
                case ($urandom_range(0, 4))
                    0: s = int'(cal_adc_m[$urandom_range(0, 2)]) + int'($urandom_range(0, 6)) - 3;
                    1: s = $urandom_range(0, 1) ? 1023 : 0;
                    default: s = $urandom_range(0, 1023);
                endcase
                if (s < 0)
                    s = 0;
                if (s > 1023)
                    s = 1023;
                send_sample(ADC_BITS'(s));
            end
        end
    endtask

    task automatic test_drain_pause();
        randomize_calibration();
        repeat (20) send_sample(ADC_BITS'($urandom));
        wait_drain();
        repeat (20) send_sample(ADC_BITS'($urandom));
    endtask

    initial begin
        foreach (cal_adc_m[i]) begin
            cal_adc_m[i] = '0;
            cal_val_m[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_interpolation();
        test_saturation();
        test_rounding();
        test_degenerate_segments();
        test_points_out_of_order();
        test_unused_index();
        test_drain_pause();
        test_random_phases();
        wait_drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0)
            $display("three_point_adc_calibration_top: match");
        else
            $display("three_point_adc_calibration_top: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("three_point_adc_calibration_top: mismatch");
        $finish;
    end

endmodule

@@ three_point_adc_calibration_top.f @@
rtl/tpac_pkg.sv
rtl/tpac_cfg.sv
rtl/tpac_front.sv
rtl/tpac_div_stage.sv
rtl/three_point_adc_calibration_top.sv
sim/tb_three_point_adc_calibration_top.sv
